FILE: rtl/core/suffix_automaton_distinct_substrings_unit_assert.svh
// Assertion macros for the suffix automaton substring counter.
// Depends on clk_i and rst_ni in the scope of use.
`ifndef SUFFIX_AUTOMATON_DISTINCT_SUBSTRINGS_UNIT_ASSERT_SVH
`define SUFFIX_AUTOMATON_DISTINCT_SUBSTRINGS_UNIT_ASSERT_SVH

// same-cycle implication
`define SADS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SADS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sads_pkg.sv
// Shared types, constants and address helper for the suffix automaton counter.
// No dependencies.
package sads_pkg;

  localparam int MAX_SYMBOLS = 4096;
  localparam int ALPHABET    = 26;

  localparam int STATE_CAP = 2 * MAX_SYMBOLS;
  localparam int STATE_W   = $clog2(STATE_CAP);
  localparam int LINK_W    = STATE_W + 1;
  localparam int USED_W    = STATE_W + 1;
  localparam int LEN_W     = $clog2(MAX_SYMBOLS + 1);
  localparam int SEEN_W    = LEN_W;
  localparam int K_W       = $clog2(ALPHABET + 1);
  localparam int TT_DEPTH  = STATE_CAP * ALPHABET;
  localparam int TT_AW     = $clog2(TT_DEPTH);
  localparam int INFO_AW   = STATE_W;
  localparam int COUNT_W   = 24;
  localparam int SYM_W     = 5;

  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {STATE_W{1'b0}}};

  typedef struct packed {
    logic             new_string;
    logic [SYM_W-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] link;
  } info_t;

  localparam int INFO_W = $bits(info_t);

  typedef struct packed {
    logic               we;
    logic [INFO_AW-1:0] waddr;
    info_t              wdata;
    logic [INFO_AW-1:0] raddr;
  } info_req_t;

  typedef struct packed {
    logic               we;
    logic [TT_AW-1:0]   waddr;
    logic [STATE_W-1:0] wdata;
    logic [TT_AW-1:0]   raddr;
  } tt_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_DISP, S_A_EV, S_ROWCLR, S_W_RD, S_W_EV, S_Q_EV,
    S_CP, S_R_RD, S_R_EV, S_QL, S_FIN, S_DONE
  } state_e;

  function automatic logic [TT_AW-1:0] tt_addr(logic [STATE_W-1:0] s,
                                               logic [TT_AW-1:0] idx);
    return TT_AW'(s) * TT_AW'(ALPHABET) + idx;
  endfunction

endpackage

FILE: rtl/core/sads_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sads_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/sads_out.sv
// Result output register between the sequencer and the downstream port.
// Depends on sads_pkg.
module sads_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  sads_pkg::out_t res_i,
  output logic          res_stall_o,
  output logic          out_valid_o,
  output sads_pkg::out_t out_o,
  input  logic          out_stall_i
);
  import sads_pkg::*;

  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic load;

  assign res_stall_o = out_valid_q && out_stall_i;
  assign load        = res_valid_i && !res_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/sads_ctrl.sv
// Sequencer for suffix automaton append, clone and count update.
// Depends on sads_pkg; drives the info and transition RAM ports.
module sads_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  sads_pkg::in_t                in_i,
  output logic                         in_stall_o,
  output sads_pkg::info_req_t          info_req_o,
  input  sads_pkg::info_t              info_rd_i,
  output sads_pkg::tt_req_t            tt_req_o,
  input  logic [sads_pkg::STATE_W-1:0] tt_rd_i,
  output logic                         res_valid_o,
  output sads_pkg::out_t               res_o,
  input  logic                         res_stall_i
);
  import sads_pkg::*;

  state_e state_q, state_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [SYM_W-1:0]   c_q, c_d;
  logic               need_clr_q, need_clr_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [STATE_W-1:0] last_q, last_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic               ovf_q, ovf_d;
  logic [STATE_W-1:0] cur_q, cur_d;
  logic [LEN_W-1:0]   cur_len_q, cur_len_d;
  logic [LINK_W-1:0]  p_q, p_d;
  logic [LEN_W-1:0]   plen_q, plen_d;
  logic [STATE_W-1:0] qst_q, qst_d;
  logic [LEN_W-1:0]   qlen_q, qlen_d;
  logic [STATE_W-1:0] cl_q, cl_d;
  logic [LINK_W-1:0]  link_q, link_d;
  logic [LEN_W-1:0]   link_len_q, link_len_d;

  logic               k_last;
  logic               sym_ok;
  logic               full;
  logic               solid;
  logic [TT_AW-1:0]   pc_addr;
  logic [COUNT_W:0]   sum;

  assign k_last  = (k_q == K_W'(ALPHABET - 1));
  assign sym_ok  = int'(c_q) < ALPHABET;
  assign full    = (seen_q >= SEEN_W'(MAX_SYMBOLS));
  assign solid   = (plen_q + LEN_W'(1)) == info_rd_i.len;
  assign pc_addr = tt_addr(p_q[STATE_W-1:0], TT_AW'(c_q));
  assign sum     = {1'b0, total_q} + (COUNT_W + 1)'(cur_len_q - link_len_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_i.new_string || need_clr_q) ? S_CLR : S_DISP;
        end
      end
      S_CLR: begin
        if (k_last) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = (sym_ok && !full) ? S_A_EV : S_DONE;
      end
      S_A_EV: state_d = S_ROWCLR;
      S_ROWCLR: begin
        if (k_last) begin
          state_d = S_W_RD;
        end
      end
      S_W_RD: state_d = S_W_EV;
      S_W_EV: begin
        if (tt_rd_i != '0) begin
          state_d = S_Q_EV;
        end else if (info_rd_i.link[LINK_W-1]) begin
          state_d = S_FIN;
        end else begin
          state_d = S_W_RD;
        end
      end
      S_Q_EV: state_d = solid ? S_FIN : S_CP;
      S_CP: begin
        if (k_q == K_W'(ALPHABET)) begin
          state_d = S_R_RD;
        end
      end
      S_R_RD: state_d = S_R_EV;
      S_R_EV: begin
        if (tt_rd_i == qst_q && !info_rd_i.link[LINK_W-1]) begin
          state_d = S_R_RD;
        end else begin
          state_d = S_QL;
        end
      end
      S_QL: state_d = S_FIN;
      S_FIN: state_d = S_DONE;
      S_DONE: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory ports and result
  always_comb begin
    info_req_o       = '0;
    tt_req_o         = '0;
    info_req_o.raddr = p_q[STATE_W-1:0];
    tt_req_o.raddr   = pc_addr;
    res_valid_o      = 1'b0;
    res_o.distinct_count = total_q;
    res_o.overflow       = ovf_q;
    case (state_q)
      S_CLR: begin
        tt_req_o.we    = 1'b1;
        tt_req_o.waddr = tt_addr('0, TT_AW'(k_q));
        if (k_q == '0) begin
          info_req_o.we         = 1'b1;
          info_req_o.waddr      = '0;
          info_req_o.wdata.len  = '0;
          info_req_o.wdata.link = LINK_NONE;
        end
      end
      S_DISP: info_req_o.raddr = last_q;
      S_ROWCLR: begin
        tt_req_o.we    = 1'b1;
        tt_req_o.waddr = tt_addr(cur_q, TT_AW'(k_q));
      end
      S_W_EV: begin
        info_req_o.raddr = tt_rd_i;
        if (tt_rd_i == '0) begin
          tt_req_o.we    = 1'b1;
          tt_req_o.waddr = pc_addr;
          tt_req_o.wdata = cur_q;
        end
      end
      S_Q_EV: begin
        if (!solid) begin
          info_req_o.we         = 1'b1;
          info_req_o.waddr      = used_q[STATE_W-1:0];
          info_req_o.wdata.len  = plen_q + LEN_W'(1);
          info_req_o.wdata.link = info_rd_i.link;
        end
      end
      S_CP: begin
        if (k_q != K_W'(ALPHABET)) begin
          tt_req_o.raddr = tt_addr(qst_q, TT_AW'(k_q));
        end
        if (k_q != '0) begin
          tt_req_o.we    = 1'b1;
          tt_req_o.waddr = tt_addr(cl_q, TT_AW'(k_q - K_W'(1)));
          tt_req_o.wdata = tt_rd_i;
        end
      end
      S_R_EV: begin
        if (tt_rd_i == qst_q) begin
          tt_req_o.we    = 1'b1;
          tt_req_o.waddr = pc_addr;
          tt_req_o.wdata = cl_q;
        end
      end
      S_QL: begin
        info_req_o.we         = 1'b1;
        info_req_o.waddr      = qst_q;
        info_req_o.wdata.len  = qlen_q;
        info_req_o.wdata.link = {1'b0, cl_q};
      end
      S_FIN: begin
        info_req_o.we         = 1'b1;
        info_req_o.waddr      = cur_q;
        info_req_o.wdata.len  = cur_len_q;
        info_req_o.wdata.link = link_q;
      end
      S_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    k_d        = k_q;
    c_d        = c_q;
    need_clr_d = need_clr_q;
    used_d     = used_q;
    last_d     = last_q;
    total_d    = total_q;
    seen_d     = seen_q;
    ovf_d      = ovf_q;
    cur_d      = cur_q;
    cur_len_d  = cur_len_q;
    p_d        = p_q;
    plen_d     = plen_q;
    qst_d      = qst_q;
    qlen_d     = qlen_q;
    cl_d       = cl_q;
    link_d     = link_q;
    link_len_d = link_len_q;
    case (state_q)
      S_IDLE: begin
        c_d  = in_i.symbol;
        k_d  = '0;
      end
      S_CLR: begin
        k_d = k_q + K_W'(1);
        if (k_last) begin
          need_clr_d = 1'b0;
          used_d     = USED_W'(1);
          last_d     = '0;
          total_d    = '0;
          seen_d     = '0;
        end
      end
      S_DISP: begin
        ovf_d = sym_ok && full;
        cur_d = used_q[STATE_W-1:0];
        if (sym_ok && !full) begin
          used_d = used_q + USED_W'(1);
        end
      end
      S_A_EV: begin
        cur_len_d = info_rd_i.len + LEN_W'(1);
        p_d       = {1'b0, last_q};
        k_d       = '0;
      end
      S_ROWCLR: k_d = k_q + K_W'(1);
      S_W_EV: begin
        if (tt_rd_i != '0) begin
          qst_d  = tt_rd_i;
          plen_d = info_rd_i.len;
        end else if (info_rd_i.link[LINK_W-1]) begin
          link_d     = '0;
          link_len_d = '0;
        end else begin
          p_d = info_rd_i.link;
        end
      end
      S_Q_EV: begin
        qlen_d = info_rd_i.len;
        k_d    = '0;
        if (solid) begin
          link_d     = {1'b0, qst_q};
          link_len_d = info_rd_i.len;
        end else begin
          cl_d   = used_q[STATE_W-1:0];
          used_d = used_q + USED_W'(1);
        end
      end
      S_CP: k_d = k_q + K_W'(1);
      S_R_EV: begin
        if (tt_rd_i == qst_q) begin
          p_d = info_rd_i.link;
        end
      end
      S_QL: begin
        link_d     = {1'b0, cl_q};
        link_len_d = plen_q + LEN_W'(1);
      end
      S_FIN: begin
        last_d  = cur_q;
        seen_d  = seen_q + SEEN_W'(1);
        total_d = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      need_clr_q <= 1'b1;
      used_q     <= USED_W'(1);
      last_q     <= '0;
      total_q    <= '0;
      seen_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      need_clr_q <= need_clr_d;
      used_q     <= used_d;
      last_q     <= last_d;
      total_q    <= total_d;
      seen_q     <= seen_d;
      ovf_q      <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    cur_q      <= cur_d;
    cur_len_q  <= cur_len_d;
    p_q        <= p_d;
    plen_q     <= plen_d;
    qst_q      <= qst_d;
    qlen_q     <= qlen_d;
    cl_q       <= cl_d;
    link_q     <= link_d;
    link_len_q <= link_len_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/suffix_automaton_distinct_substrings_unit.sv
// Top level: suffix automaton distinct substring counter.
// Depends on sads_pkg, sads_ram, sads_ctrl, sads_out and the assert header.
//
//   port group   dir   beat contents
//   in_*         in    new_string, symbol
//   out_*        out   distinct_count, overflow
//
// One item at a time: the new state's row is cleared, then the suffix-link walk checks
// states until a transition is found or the walk passes the root; a clone copies the
// row of the found state and walks the redirect chain. A dropped symbol skips the append.
// A clearing item first rewrites the root row.
// After reset the first item always clears the root row.
// The next item is taken while the previous result waits in the output register.
module suffix_automaton_distinct_substrings_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sads_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sads_pkg::out_t out_o
);
  import sads_pkg::*;

  `include "suffix_automaton_distinct_substrings_unit_assert.svh"

  info_req_t          info_req;
  info_t              info_rd;
  tt_req_t            tt_req;
  logic [STATE_W-1:0] tt_rd;
  logic               res_valid;
  out_t               res;
  logic               res_stall;

  sads_ram #(
    .WIDTH (INFO_W),
    .DEPTH (STATE_CAP)
  ) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_req.we),
    .waddr_i (info_req.waddr),
    .wdata_i (info_req.wdata),
    .raddr_i (info_req.raddr),
    .rdata_o (info_rd)
  );

  sads_ram #(
    .WIDTH (STATE_W),
    .DEPTH (TT_DEPTH)
  ) u_tt_ram (
    .clk_i   (clk_i),
    .we_i    (tt_req.we),
    .waddr_i (tt_req.waddr),
    .wdata_i (tt_req.wdata),
    .raddr_i (tt_req.raddr),
    .rdata_o (tt_rd)
  );

  sads_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .info_req_o  (info_req),
    .info_rd_i   (info_rd),
    .tt_req_o    (tt_req),
    .tt_rd_i     (tt_rd),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_stall_i (res_stall)
  );

  sads_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_stall_o (res_stall),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

  `SADS_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                   "sequencer idle right after accepting a beat")
  `SADS_ASSERT_IMP(a_result_while_busy, res_valid, in_stall_o,
                   "result offered while input side is open")
  `SADS_ASSERT_NXT(a_single_result, res_valid && !res_stall, !res_valid,
                   "second result offered for one beat")

endmodule

FILE: tb/testbench.sv
// Self-checking bench for suffix_automaton_distinct_substrings_unit.
// Depends on sads_pkg and the unit; predicts each distinct-substring count
// from a private suffix automaton and drives random idling on both channels.
module testbench;

  import sads_pkg::*;

  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          TAIL_CYCLES  = 200;
  localparam int unsigned NO_LINK      = 32'hFFFF_FFFF;
  localparam int unsigned COUNT_SAT    = 32'h00FF_FFFF;

  class substring_board;
    int unsigned len_of[STATE_CAP];
    int unsigned link_of[STATE_CAP];
    int unsigned next_of[STATE_CAP][ALPHABET];
    int unsigned states_used, last_state, total, seen;
    out_t        pending[$];
    int          errors;

    function new();
      clear_string();
      errors = 0;
    endfunction

    function void clear_string();
      len_of[0] = 0;
      link_of[0] = NO_LINK;
      for (int k = 0; k < ALPHABET; k++) next_of[0][k] = 0;
      states_used = 1;
      last_state = 0;
      total = 0;
      seen = 0;
    endfunction

    function void append_symbol(int unsigned c);
      int unsigned cur, p, q, cl, gain;
      cur = states_used++;
      p = last_state;
      len_of[cur] = len_of[last_state] + 1;
      for (int k = 0; k < ALPHABET; k++) next_of[cur][k] = 0;
      while (p != NO_LINK && next_of[p][c] == 0) begin
        next_of[p][c] = cur;
        p = link_of[p];
      end
      if (p == NO_LINK) begin
        link_of[cur] = 0;
      end else begin
        q = next_of[p][c];
        if (len_of[p] + 1 == len_of[q]) begin
          link_of[cur] = q;
        end else begin
          cl = states_used++;
          len_of[cl] = len_of[p] + 1;
          for (int k = 0; k < ALPHABET; k++) next_of[cl][k] = next_of[q][k];
          link_of[cl] = link_of[q];
          while (p != NO_LINK && next_of[p][c] == q) begin
            next_of[p][c] = cl;
            p = link_of[p];
          end
          link_of[q] = cl;
          link_of[cur] = cl;
        end
      end
      last_state = cur;
      seen++;
      gain = len_of[cur] - len_of[link_of[cur]];
      if (gain > COUNT_SAT - total) total = COUNT_SAT;
      else total += gain;
    endfunction

    function void note_symbol(in_t b);
      out_t r;
      r.overflow = 1'b0;
      if (b.new_string) clear_string();
      if (b.symbol < ALPHABET) begin
        if (seen >= MAX_SYMBOLS) r.overflow = 1'b1;
        else append_symbol(b.symbol);
      end
      r.distinct_count = total[COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat count=%0d ovf=%0b",
                                  got.distinct_count, got.overflow));
      end else begin
        want = pending.pop_front();
        if (got.distinct_count !== want.distinct_count)
          report_mismatch($sformatf("distinct_count got %0d want %0d",
                                    got.distinct_count, want.distinct_count));
        if (got.overflow !== want.overflow)
          report_mismatch($sformatf("overflow got %0b want %0b",
                                    got.overflow, want.overflow));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  substring_board board = new();
  bit             calm = 1'b0;
  int             cycles = 0;

  suffix_automaton_distinct_substrings_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_symbol(in_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_o);
  end

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 37);
  end

  task send_symbol(bit clr, int unsigned sym);
    in_t b;
    bit  taken;
    b.new_string = clr;
    b.symbol = sym[SYM_W-1:0];
    in_valid_i <= 1'b1;
    in_i <= b;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task drain();
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned span, sym;
    bit          clr;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_symbol(0, 0);
    send_symbol(0, 0);
    send_symbol(0, 0);
    send_symbol(0, 1);
    send_symbol(0, 0);
    send_symbol(0, 1);
    send_symbol(0, 25);
    send_symbol(0, 26);
    send_symbol(0, 31);
    send_symbol(1, 31);
    send_symbol(0, 25);
    send_symbol(1, 25);
    send_symbol(0, 25);
    send_symbol(0, 0);
    send_symbol(0, 25);
    send_symbol(1, 0);
    send_symbol(0, 1);
    send_symbol(0, 0);
    send_symbol(0, 1);
    send_symbol(0, 16);
    send_symbol(0, 15);

    in_valid_i <= 1'b0;
    drain();

    span = 3;
    for (int n = 0; n < 380; n++) begin
      if (n == 150) begin
        in_valid_i <= 1'b0;
        drain();
      end
      calm = (n >= 200 && n < 260);
      clr = ($urandom_range(99) < 6);
      if (clr) span = ($urandom_range(2) == 0) ? 26 : $urandom_range(2, 4);
      if ($urandom_range(99) < 5) sym = $urandom_range(26, 31);
      else sym = $urandom_range(span - 1);
      send_symbol(clr, sym);
    end

    calm = 1'b0;
    send_symbol(0, 30);
    send_symbol(1, 3);

    in_valid_i <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
